>>> hdl/pbcr_pkg.sv
// ----------------------------------------------------------------------------
// pbcr_pkg: shared types and constants for the particle box collision block
// Item and result records, face codes, register indexes, reset values and
// the fixed-point helpers for saturation and velocity scale factors.
// ----------------------------------------------------------------------------
package pbcr_pkg;

    // One particle on the input side
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] prev_x;
        logic signed [31:0] prev_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic               is_fixed;
    } t_in_item;

    // One particle on the output side
    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_prev_x;
        logic signed [31:0] new_prev_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic [2:0]         hit_face;
    } t_out_item;

    // Face that was crossed
    typedef enum logic [2:0] {
        FACE_NONE   = 3'd0,
        FACE_BOTTOM = 3'd1,
        FACE_LEFT   = 3'd2,
        FACE_RIGHT  = 3'd3,
        FACE_TOP    = 3'd4
    } t_face;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_CORNER_A_X   = 3'd0;
    localparam logic [2:0] REG_CORNER_A_Y   = 3'd1;
    localparam logic [2:0] REG_CORNER_B_X   = 3'd2;
    localparam logic [2:0] REG_CORNER_B_Y   = 3'd3;
    localparam logic [2:0] REG_ABSORPTION   = 3'd4;
    localparam logic [2:0] REG_PUSH_MARGIN  = 3'd5;
    localparam logic [2:0] REG_TIME_STEP    = 3'd6;

    // Register reset values
    localparam logic signed [31:0] CORNER_A_RESET   = 32'sd0;
    localparam logic signed [31:0] CORNER_B_RESET   = 32'sd65536;
    localparam logic [15:0]        ABSORPTION_RESET = 16'd6554;
    localparam logic [15:0]        MARGIN_RESET     = 16'd1;
    localparam logic [23:0]        TIME_STEP_RESET  = 24'd655;

    // 0.1 in Q0.16 and 1.0 in Q1.16 for the scale factors
    localparam logic [13:0] TENTH_Q16 = 14'd6554;
    localparam logic [16:0] ONE_Q16   = 17'd65536;

    localparam logic signed [47:0] SAT_MAX = 48'sd2147483647;
    localparam logic signed [47:0] SAT_MIN = -48'sd2147483648;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
        logic signed [31:0] res;
        if (x > SAT_MAX) begin
            res = 32'sh7FFF_FFFF;
        end else if (x < SAT_MIN) begin
            res = 32'sh8000_0000;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

    // Normal factor 1 - a, Q1.16
    function automatic logic [16:0] perp_factor(input logic [15:0] a);
        return ONE_Q16 - {1'b0, a};
    endfunction

    // Tangential factor 1 - round(0.1 a), Q1.16
    function automatic logic [16:0] par_factor(input logic [15:0] a);
        logic [29:0] prod;
        prod = 30'(a) * 30'(TENTH_Q16) + 30'd32768;
        return ONE_Q16 - {3'b000, prod[29:16]};
    endfunction

    localparam logic [16:0] PERP_RESET = perp_factor(ABSORPTION_RESET);
    localparam logic [16:0] PAR_RESET  = par_factor(ABSORPTION_RESET);

endpackage

>>> hdl/particle_box_collision_response.sv
// ----------------------------------------------------------------------------
// particle_box_collision_response: wall box collision response, Q16.16
// Four register stages lie between input transfer and output valid.
// Throughput: one particle per cycle while the output is not stalled; the face
// test, multiply, round and saturate stages each hold only while full and stalled.
// Reset (synchronous, active low) empties the pipeline and loads box defaults.
// ----------------------------------------------------------------------------
module particle_box_collision_response
    import pbcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // particle input
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    // particle output
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data
);

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic signed [31:0] r_corner_a_x, r_corner_a_y, r_corner_b_x, r_corner_b_y;
    logic signed [31:0] r_left, r_right, r_bottom, r_top;
    logic [16:0]        r_perp, r_par;
    logic [15:0]        r_margin;
    logic [23:0]        r_time_step;
    logic signed [31:0] cfg_s;

    assign o_cfg_ready = 1'b1;
    assign cfg_s       = $signed(i_cfg_data);

    // Keep box extents and scale factors precomputed at write time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner_a_x <= CORNER_A_RESET;
            r_corner_a_y <= CORNER_A_RESET;
            r_corner_b_x <= CORNER_B_RESET;
            r_corner_b_y <= CORNER_B_RESET;
            r_left       <= CORNER_A_RESET;
            r_right      <= CORNER_B_RESET;
            r_bottom     <= CORNER_A_RESET;
            r_top        <= CORNER_B_RESET;
            r_perp       <= PERP_RESET;
            r_par        <= PAR_RESET;
            r_margin     <= MARGIN_RESET;
            r_time_step  <= TIME_STEP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_CORNER_A_X: begin
                    r_corner_a_x <= cfg_s;
                    r_left  <= (cfg_s < r_corner_b_x) ? cfg_s : r_corner_b_x;
                    r_right <= (cfg_s < r_corner_b_x) ? r_corner_b_x : cfg_s;
                end
                REG_CORNER_A_Y: begin
                    r_corner_a_y <= cfg_s;
                    r_bottom <= (cfg_s < r_corner_b_y) ? cfg_s : r_corner_b_y;
                    r_top    <= (cfg_s < r_corner_b_y) ? r_corner_b_y : cfg_s;
                end
                REG_CORNER_B_X: begin
                    r_corner_b_x <= cfg_s;
                    r_left  <= (r_corner_a_x < cfg_s) ? r_corner_a_x : cfg_s;
                    r_right <= (r_corner_a_x < cfg_s) ? cfg_s : r_corner_a_x;
                end
                REG_CORNER_B_Y: begin
                    r_corner_b_y <= cfg_s;
                    r_bottom <= (r_corner_a_y < cfg_s) ? r_corner_a_y : cfg_s;
                    r_top    <= (r_corner_a_y < cfg_s) ? cfg_s : r_corner_a_y;
                end
                REG_ABSORPTION: begin
                    r_perp <= perp_factor(i_cfg_data[15:0]);
                    r_par  <= par_factor(i_cfg_data[15:0]);
                end
                REG_PUSH_MARGIN: begin
                    r_margin <= i_cfg_data[15:0];
                end
                REG_TIME_STEP: begin
                    r_time_step <= i_cfg_data[23:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Pipeline flow control: a stage advances when it is empty or drains
    // ------------------------------------------------------------------------
    logic r1_valid, r2_valid, r3_valid, r4_valid;
    logic adv1, adv2, adv3, adv4;

    assign adv4        = !r4_valid || i_out_ready;
    assign adv3        = !r3_valid || adv4;
    assign adv2        = !r2_valid || adv3;
    assign adv1        = !r1_valid || adv2;
    assign o_in_ready  = adv1;
    assign o_out_valid = r4_valid;

    // ------------------------------------------------------------------------
    // Stage 1: face test against the box
    // ------------------------------------------------------------------------
    t_in_item r1_item;
    t_face    r1_face, n1_face;
    logic     in_x, in_y;

    always_comb begin
        in_x    = (i_in_data.prev_x >= r_left) && (i_in_data.prev_x <= r_right);
        in_y    = (i_in_data.prev_y >= r_bottom) && (i_in_data.prev_y <= r_top);
        n1_face = FACE_NONE;
        if (!i_in_data.is_fixed) begin
            if (i_in_data.prev_y <= r_bottom && i_in_data.pos_y >= r_bottom && in_x) begin
                n1_face = FACE_BOTTOM;
            end else if (i_in_data.prev_x <= r_left && i_in_data.pos_x >= r_left && in_y) begin
                n1_face = FACE_LEFT;
            end else if (i_in_data.prev_x >= r_right && i_in_data.pos_x <= r_right
                         && in_y) begin
                n1_face = FACE_RIGHT;
            end else if (i_in_data.prev_y >= r_top && i_in_data.pos_y <= r_top && in_x) begin
                n1_face = FACE_TOP;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stage 2: velocity and step products, pushed coordinate
    // ------------------------------------------------------------------------
    t_in_item           r2_item;
    t_face              r2_face;
    logic signed [49:0] r2_mul_x, r2_mul_y, n2_mul_x, n2_mul_y;
    logic signed [56:0] r2_step_x, r2_step_y, n2_step_x, n2_step_y;
    logic signed [31:0] r2_push, n2_push;
    logic               vert;
    logic [16:0]        fac_x, fac_y;
    logic signed [47:0] margin_w, push_w;

    always_comb begin
        vert      = (r1_face == FACE_BOTTOM) || (r1_face == FACE_TOP);
        fac_x     = vert ? r_par : r_perp;
        fac_y     = vert ? r_perp : r_par;
        n2_mul_x  = r1_item.vel_x * $signed({1'b0, fac_x});
        n2_mul_y  = r1_item.vel_y * $signed({1'b0, fac_y});
        n2_step_x = r1_item.vel_x * $signed({1'b0, r_time_step});
        n2_step_y = r1_item.vel_y * $signed({1'b0, r_time_step});
        margin_w  = $signed({32'd0, r_margin});
        case (r1_face)
            FACE_BOTTOM: push_w = 48'(r_bottom) - margin_w;
            FACE_LEFT:   push_w = 48'(r_left) - margin_w;
            FACE_RIGHT:  push_w = 48'(r_right) + margin_w;
            FACE_TOP:    push_w = 48'(r_top) + margin_w;
            default:     push_w = '0;
        endcase
        n2_push = sat32(push_w);
    end

    // ------------------------------------------------------------------------
    // Stage 3: round products to Q16.16, half toward plus infinity
    // ------------------------------------------------------------------------
    t_in_item           r3_item;
    t_face              r3_face;
    logic signed [31:0] r3_push;
    logic signed [33:0] r3_rnd_x, r3_rnd_y;
    logic signed [40:0] r3_step_x, r3_step_y;
    logic signed [49:0] sum_x, sum_y;
    logic signed [56:0] sum_sx, sum_sy;

    always_comb begin
        sum_x  = r2_mul_x + 50'sd32768;
        sum_y  = r2_mul_y + 50'sd32768;
        sum_sx = r2_step_x + 57'sd32768;
        sum_sy = r2_step_y + 57'sd32768;
    end

    // ------------------------------------------------------------------------
    // Stage 4: negate normal, saturate, assemble result
    // ------------------------------------------------------------------------
    t_out_item          r4_out, n4_out;
    logic signed [47:0] scl_x, scl_y, neg_x, neg_y, prv_x, prv_y;

    always_comb begin
        scl_x  = 48'(r3_rnd_x);
        scl_y  = 48'(r3_rnd_y);
        neg_x  = -scl_x;
        neg_y  = -scl_y;
        prv_x  = 48'(r3_item.pos_x) - 48'(r3_step_x);
        prv_y  = 48'(r3_item.pos_y) - 48'(r3_step_y);
        n4_out.new_pos_x  = r3_item.pos_x;
        n4_out.new_pos_y  = r3_item.pos_y;
        n4_out.new_prev_x = r3_item.prev_x;
        n4_out.new_prev_y = r3_item.prev_y;
        n4_out.new_vel_x  = r3_item.vel_x;
        n4_out.new_vel_y  = r3_item.vel_y;
        n4_out.hit_face   = r3_face;
        case (r3_face)
            FACE_BOTTOM, FACE_TOP: begin
                n4_out.new_pos_y  = r3_push;
                n4_out.new_vel_x  = sat32(scl_x);
                n4_out.new_vel_y  = sat32(neg_y);
                n4_out.new_prev_x = sat32(prv_x);
                n4_out.new_prev_y = sat32(prv_y);
            end
            FACE_LEFT, FACE_RIGHT: begin
                n4_out.new_pos_x  = r3_push;
                n4_out.new_vel_x  = sat32(neg_x);
                n4_out.new_vel_y  = sat32(scl_y);
                n4_out.new_prev_x = sat32(prv_x);
                n4_out.new_prev_y = sat32(prv_y);
            end
            default: begin
            end
        endcase
    end

    assign o_out_data = r4_out;

    // ------------------------------------------------------------------------
    // Stage registers: valid bits reset, payload advances with its stage
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (adv1) r1_valid <= i_in_valid;
            if (adv2) r2_valid <= r1_valid;
            if (adv3) r3_valid <= r2_valid;
            if (adv4) r4_valid <= r3_valid;
        end
        if (adv1 && i_in_valid) begin
            r1_item <= i_in_data;
            r1_face <= n1_face;
        end
        if (adv2 && r1_valid) begin
            r2_item   <= r1_item;
            r2_face   <= r1_face;
            r2_mul_x  <= n2_mul_x;
            r2_mul_y  <= n2_mul_y;
            r2_step_x <= n2_step_x;
            r2_step_y <= n2_step_y;
            r2_push   <= n2_push;
        end
        if (adv3 && r2_valid) begin
            r3_item   <= r2_item;
            r3_face   <= r2_face;
            r3_push   <= r2_push;
            r3_rnd_x  <= sum_x[49:16];
            r3_rnd_y  <= sum_y[49:16];
            r3_step_x <= sum_sx[56:16];
            r3_step_y <= sum_sy[56:16];
        end
        if (adv4 && r3_valid) begin
            r4_out <= n4_out;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_fixed_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r1_valid && r1_item.is_fixed |-> r1_face == FACE_NONE)
        else $error("pinned particle reported a face hit");

    a_box_x_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= r_right)
        else $error("box left edge beyond right edge");

    a_box_y_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bottom <= r_top)
        else $error("box bottom edge beyond top edge");

    a_bottom_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.hit_face == FACE_BOTTOM |->
            o_out_data.new_pos_y <= r_bottom)
        else $error("bottom hit left particle inside the box");

    a_top_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.hit_face == FACE_TOP |->
            o_out_data.new_pos_y >= r_top)
        else $error("top hit left particle inside the box");

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for particle_box_collision_response
// Streams particles through the block over valid/ready with random gaps and
// output stalls, predicts each result from a local Q16.16 model of the box
// collision response, and compares every returned particle field by field.
// Register settings change between phases, with the box and factors taken to
// their extremes, swapped and degenerate corners among them.
// ----------------------------------------------------------------------------
module tb;
    import pbcr_pkg::*;

    localparam int     ONE       = 65536;
    localparam int     HALF      = 32768;
    localparam longint TENTH     = 6554;
    localparam longint Q_MIN     = -64'sd2147483648;
    localparam longint Q_MAX     = 64'sd2147483647;
    localparam logic signed [31:0] W_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] W_MAX = 32'sh7FFF_FFFF;
    localparam int     LONG_HOLD = 60;
    localparam int     QUIET_MAX = 2000;

    typedef struct {
        t_in_item  din;
        bit        typed;
        t_out_item dout;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in_item    i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out_item   o_out_data;

    // local copy of the register file
    logic signed [31:0] cfg_ax, cfg_ay, cfg_bx, cfg_by;
    logic [15:0]        cfg_absorb, cfg_margin;
    logic [23:0]        cfg_step;

    t_out_item   awaited[$];
    t_row        directed_rows[$];
    int unsigned mismatches = 0;
    int unsigned quiet      = 0;
    bit          tx_idle    = 1'b0;
    bit          tx_burst   = 1'b0;

    particle_box_collision_response dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic signed [31:0] clamp32(input longint x);
        if (x > Q_MAX) begin
            return 32'sh7FFF_FFFF;
        end else if (x < Q_MIN) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    // floor of (x + 0.5) in Q16, i.e. round half up
    function automatic longint round_q16(input longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    function automatic void box_extent(output longint lo_x, output longint hi_x,
                                       output longint lo_y, output longint hi_y);
        lo_x = (cfg_ax < cfg_bx) ? cfg_ax : cfg_bx;
        hi_x = (cfg_ax < cfg_bx) ? cfg_bx : cfg_ax;
        lo_y = (cfg_ay < cfg_by) ? cfg_ay : cfg_by;
        hi_y = (cfg_ay < cfg_by) ? cfg_by : cfg_ay;
    endfunction

    function automatic t_out_item bounce_particle(input t_in_item p);
        longint    px, py, qx, qy, vx, vy;
        longint    lo_x, hi_x, lo_y, hi_y;
        longint    absorb, margin, step, perp, par;
        logic      in_x, in_y;
        t_face     f;
        t_out_item r;
        px = p.pos_x;
        py = p.pos_y;
        qx = p.prev_x;
        qy = p.prev_y;
        vx = p.vel_x;
        vy = p.vel_y;
        box_extent(lo_x, hi_x, lo_y, hi_y);
        absorb = longint'(cfg_absorb);
        margin = longint'(cfg_margin);
        step   = longint'(cfg_step);
        perp   = ONE - absorb;
        par    = ONE - ((absorb * TENTH + 64'sd32768) >>> 16);
        in_x   = (qx >= lo_x) && (qx <= hi_x);
        in_y   = (qy >= lo_y) && (qy <= hi_y);

        r.new_pos_x  = p.pos_x;
        r.new_pos_y  = p.pos_y;
        r.new_prev_x = p.prev_x;
        r.new_prev_y = p.prev_y;
        r.new_vel_x  = p.vel_x;
        r.new_vel_y  = p.vel_y;

        // first matching face wins: bottom, left, right, top
        f = FACE_NONE;
        if (!p.is_fixed) begin
            if (qy <= lo_y && py >= lo_y && in_x) begin
                f = FACE_BOTTOM;
            end else if (qx <= lo_x && px >= lo_x && in_y) begin
                f = FACE_LEFT;
            end else if (qx >= hi_x && px <= hi_x && in_y) begin
                f = FACE_RIGHT;
            end else if (qy >= hi_y && py <= hi_y && in_x) begin
                f = FACE_TOP;
            end
        end

        if (f != FACE_NONE) begin
            if (f == FACE_BOTTOM || f == FACE_TOP) begin
                r.new_pos_y = clamp32(f == FACE_BOTTOM ? lo_y - margin : hi_y + margin);
                r.new_vel_x = clamp32(round_q16(vx * par));
                r.new_vel_y = clamp32(-round_q16(vy * perp));
            end else begin
                r.new_pos_x = clamp32(f == FACE_LEFT ? lo_x - margin : hi_x + margin);
                r.new_vel_x = clamp32(-round_q16(vx * perp));
                r.new_vel_y = clamp32(round_q16(vy * par));
            end
            r.new_prev_x = clamp32(px - round_q16(step * vx));
            r.new_prev_y = clamp32(py - round_q16(step * vy));
        end
        r.hit_face = f;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic t_in_item make_particle(
        input logic signed [31:0] px, py, qx, qy, vx, vy, input logic fixed_flag);
        t_in_item p;
        p.pos_x    = px;
        p.pos_y    = py;
        p.prev_x   = qx;
        p.prev_y   = qy;
        p.vel_x    = vx;
        p.vel_y    = vy;
        p.is_fixed = fixed_flag;
        return p;
    endfunction

    function automatic t_out_item make_result(
        input logic signed [31:0] px, py, qx, qy, vx, vy, input t_face f);
        t_out_item r;
        r.new_pos_x  = px;
        r.new_pos_y  = py;
        r.new_prev_x = qx;
        r.new_prev_y = qy;
        r.new_vel_x  = vx;
        r.new_vel_y  = vy;
        r.hit_face   = f;
        return r;
    endfunction

    // value in [lo, hi], biased toward both ends so faces get hit exactly
    function automatic longint pick_between(input longint lo, input longint hi);
        longint unsigned span, lim, r;
        span = longint'(hi - lo) + 1;
        lim  = ($urandom_range(0, 1) != 0) ? 3 : 262144;
        if (span < lim) begin
            lim = span;
        end
        r = {$urandom, $urandom};
        case ($urandom_range(0, 2))
            0:       return lo + longint'(r % lim);
            1:       return hi - longint'(r % lim);
            default: return lo + longint'(r % span);
        endcase
    endfunction

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(0, 6))
            0, 1, 2: return $urandom;
            3, 4:    return int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
            5:       return $urandom_range(0, 65535) << $urandom_range(0, 16);
            default: begin
                case ($urandom_range(0, 3))
                    0:       return W_MIN;
                    1:       return W_MAX;
                    2:       return 0;
                    default: return -1;
                endcase
            end
        endcase
    endfunction

    // mostly face crossings with random content, the rest inside or noise
    function automatic t_in_item craft_particle();
        t_in_item p;
        longint   lo_x, hi_x, lo_y, hi_y;
        box_extent(lo_x, hi_x, lo_y, hi_y);
        p.pos_x    = rand_word();
        p.pos_y    = rand_word();
        p.prev_x   = rand_word();
        p.prev_y   = rand_word();
        p.vel_x    = rand_word();
        p.vel_y    = rand_word();
        p.is_fixed = ($urandom_range(0, 7) == 0);
        case ($urandom_range(0, 5))
            1: begin
                p.prev_x = 32'(pick_between(lo_x, hi_x));
                p.prev_y = 32'(pick_between(Q_MIN, lo_y));
                p.pos_y  = 32'(pick_between(lo_y, Q_MAX));
            end
            2: begin
                p.prev_x = 32'(pick_between(Q_MIN, lo_x));
                p.pos_x  = 32'(pick_between(lo_x, Q_MAX));
                p.prev_y = 32'(pick_between(lo_y, hi_y));
            end
            3: begin
                p.prev_x = 32'(pick_between(hi_x, Q_MAX));
                p.pos_x  = 32'(pick_between(Q_MIN, hi_x));
                p.prev_y = 32'(pick_between(lo_y, hi_y));
            end
            4: begin
                p.prev_y = 32'(pick_between(hi_y, Q_MAX));
                p.pos_y  = 32'(pick_between(Q_MIN, hi_y));
                p.prev_x = 32'(pick_between(lo_x, hi_x));
            end
            5: begin
                p.prev_x = 32'(pick_between(lo_x, hi_x));
                p.prev_y = 32'(pick_between(lo_y, hi_y));
                p.pos_x  = 32'(pick_between(lo_x, hi_x));
                p.pos_y  = 32'(pick_between(lo_y, hi_y));
            end
            default: ;
        endcase
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            REG_CORNER_A_X:  cfg_ax     = val;
            REG_CORNER_A_Y:  cfg_ay     = val;
            REG_CORNER_B_X:  cfg_bx     = val;
            REG_CORNER_B_Y:  cfg_by     = val;
            REG_ABSORPTION:  cfg_absorb = val[15:0];
            REG_PUSH_MARGIN: cfg_margin = val[15:0];
            REG_TIME_STEP:   cfg_step   = val[23:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic program_box(input logic signed [31:0] ax, ay, bx, by,
                               input logic [15:0] absorb, margin,
                               input logic [23:0] step);
        write_reg(REG_CORNER_A_X, ax);
        write_reg(REG_CORNER_A_Y, ay);
        write_reg(REG_CORNER_B_X, bx);
        write_reg(REG_CORNER_B_Y, by);
        write_reg(REG_ABSORPTION, {16'd0, absorb});
        write_reg(REG_PUSH_MARGIN, {16'd0, margin});
        write_reg(REG_TIME_STEP, {8'd0, step});
        i_cfg_valid <= 1'b0;
    endtask

    // hold valid with a steady payload until the transfer, then queue the result
    task automatic offer(input t_in_item item, input t_out_item want);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, 14) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        awaited.push_back(want);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (awaited.size() != 0) @(negedge i_clk);
    endtask

    task automatic run_phase(input int count, input bit burst);
        t_in_item item;
        tx_burst = burst;
        for (int k = 0; k < count; k++) begin
            if (k % 20 == 0) begin
                tx_idle = !burst && ($urandom_range(0, 3) != 0);
            end
            item = craft_particle();
            offer(item, bounce_particle(item));
        end
        i_in_valid <= 1'b0;
        tx_burst = 1'b0;
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stall before each transfer, one long hold-off in the
    // burst phase so the pipeline backs up into the input
    // ------------------------------------------------------------------------
    initial begin : receiver
        int unsigned stall, taken;
        bit          rx_idle, held;
        i_out_ready = 1'b0;
        stall   = 0;
        taken   = 0;
        rx_idle = 1'b1;
        held    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
                taken++;
                if (taken % 40 == 0) begin
                    rx_idle = ($urandom_range(0, 3) != 0);
                end
                stall = rx_idle ? $urandom_range(0, 14) : 0;
                if (tx_burst && !held) begin
                    stall = LONG_HOLD;
                    held  = 1'b1;
                end
            end
            @(negedge i_clk);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                stall--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result check against the oldest expectation
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (awaited.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p",
                         $time, o_out_data);
                mismatches++;
            end else begin
                want = awaited.pop_front();
                check_field("new_pos_x", want.new_pos_x, o_out_data.new_pos_x);
                check_field("new_pos_y", want.new_pos_y, o_out_data.new_pos_y);
                check_field("new_prev_x", want.new_prev_x, o_out_data.new_prev_x);
                check_field("new_prev_y", want.new_prev_y, o_out_data.new_prev_y);
                check_field("new_vel_x", want.new_vel_x, o_out_data.new_vel_x);
                check_field("new_vel_y", want.new_vel_y, o_out_data.new_vel_y);
                check_field("hit_face", want.hit_face, o_out_data.hit_face);
            end
        end
    end

    // end the run if no transfer of any kind happens for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready)
            || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_MAX) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet);
            $display("tb failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        t_row row;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;

        // reset register values; box is [0, 1] x [0, 1]
        cfg_ax     = CORNER_A_RESET;
        cfg_ay     = CORNER_A_RESET;
        cfg_bx     = CORNER_B_RESET;
        cfg_by     = CORNER_B_RESET;
        cfg_absorb = ABSORPTION_RESET;
        cfg_margin = MARGIN_RESET;
        cfg_step   = TIME_STEP_RESET;

        // pinned, inside and far-away particles pass through
        row = '{make_particle(HALF, HALF, HALF, -HALF, 3 * ONE, -2 * ONE, 1'b1), 1'b1,
                make_result(HALF, HALF, HALF, -HALF, 3 * ONE, -2 * ONE, FACE_NONE)};
        directed_rows.push_back(row);
        row = '{make_particle(HALF, HALF, ONE / 4, ONE / 4, ONE, ONE, 1'b0), 1'b1,
                make_result(HALF, HALF, ONE / 4, ONE / 4, ONE, ONE, FACE_NONE)};
        directed_rows.push_back(row);
        row = '{make_particle(W_MAX, W_MAX, W_MIN, W_MIN, W_MIN, W_MAX, 1'b0), 1'b1,
                make_result(W_MAX, W_MAX, W_MIN, W_MIN, W_MIN, W_MAX, FACE_NONE)};
        directed_rows.push_back(row);
        row = '{make_particle(W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN, 1'b1), 1'b1,
                make_result(W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN, FACE_NONE)};
        directed_rows.push_back(row);
        row = '{make_particle(0, 0, 0, 0, 0, 0, 1'b1), 1'b1,
                make_result(0, 0, 0, 0, 0, 0, FACE_NONE)};
        directed_rows.push_back(row);
        // each face at rest: pushed out by the margin, prev snaps to pos
        row = '{make_particle(HALF, HALF, HALF, -HALF, 0, 0, 1'b0), 1'b1,
                make_result(HALF, -1, HALF, HALF, 0, 0, FACE_BOTTOM)};
        directed_rows.push_back(row);
        row = '{make_particle(HALF, HALF, -HALF, HALF, 0, 0, 1'b0), 1'b1,
                make_result(-1, HALF, HALF, HALF, 0, 0, FACE_LEFT)};
        directed_rows.push_back(row);
        row = '{make_particle(HALF, HALF, ONE + HALF, HALF, 0, 0, 1'b0), 1'b1,
                make_result(ONE + 1, HALF, HALF, HALF, 0, 0, FACE_RIGHT)};
        directed_rows.push_back(row);
        row = '{make_particle(HALF, HALF, HALF, ONE + HALF, 0, 0, 1'b0), 1'b1,
                make_result(HALF, ONE + 1, HALF, HALF, 0, 0, FACE_TOP)};
        directed_rows.push_back(row);
        // each face in motion
        row.typed = 1'b0;
        row.din = make_particle(HALF, HALF, HALF, -HALF, ONE, -3 * ONE, 1'b0);
        directed_rows.push_back(row);
        row.din = make_particle(HALF, HALF, -HALF, HALF, -2 * ONE, HALF, 1'b0);
        directed_rows.push_back(row);
        row.din = make_particle(HALF, HALF, ONE + HALF, HALF, 5 * ONE, -ONE, 1'b0);
        directed_rows.push_back(row);
        row.din = make_particle(HALF, HALF, HALF, ONE + HALF, ONE, 7 * ONE, 1'b0);
        directed_rows.push_back(row);
        // corners: bottom beats left, right beats top
        row.din = make_particle(HALF, HALF, 0, 0, ONE, ONE, 1'b0);
        directed_rows.push_back(row);
        row.din = make_particle(HALF, HALF, ONE, ONE, -ONE, -ONE, 1'b0);
        directed_rows.push_back(row);
        // resting on the face counts as a crossing
        row.din = make_particle(HALF, 0, HALF, 0, 3, -3, 1'b0);
        directed_rows.push_back(row);
        // overflow of the previous position and extreme velocities
        row.din = make_particle(W_MIN, W_MAX, HALF, -HALF, W_MAX, W_MIN, 1'b0);
        directed_rows.push_back(row);
        row.din = make_particle(W_MAX, 0, -HALF, HALF, W_MIN, W_MAX, 1'b0);
        directed_rows.push_back(row);
        // rounding of tiny and half-step velocities
        row.din = make_particle(HALF, ONE, HALF, ONE, -1, 1, 1'b0);
        directed_rows.push_back(row);
        row.din = make_particle(HALF, HALF, HALF, -HALF, -HALF, HALF, 1'b0);
        directed_rows.push_back(row);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows under reset settings
        tx_idle = 1'b1;
        foreach (directed_rows[k]) begin
            offer(directed_rows[k].din,
                  directed_rows[k].typed ? directed_rows[k].dout
                                         : bounce_particle(directed_rows[k].din));
        end
        i_in_valid <= 1'b0;
        wait_drained();

        // no absorption, no margin, no time step; back-to-back with a long stall
        program_box(-10 * ONE, -5 * ONE, 10 * ONE, 5 * ONE, 16'd0, 16'd0, 24'd0);
        run_phase(60, 1'b1);
        // swapped corners, full absorption, margin and time step
        program_box(20 * ONE, 8 * ONE, -3 * ONE, -8 * ONE, 16'hFFFF, 16'hFFFF,
                    24'hFF_FFFF);
        run_phase(60, 1'b0);
        // box spans the whole range so pushed positions saturate
        program_box(W_MIN, W_MIN, W_MAX, W_MAX, 16'($urandom_range(0, 65535)), 16'hFFFF,
                    24'($urandom_range(0, 24'hFF_FFFF)));
        run_phase(40, 1'b0);
        // degenerate box collapsed to a point
        program_box(3 * ONE, -2 * ONE, 3 * ONE, -2 * ONE, 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)), 24'($urandom_range(0, 24'hFF_FFFF)));
        run_phase(40, 1'b0);
        // random settings
        for (int ph = 0; ph < 5; ph++) begin
            program_box(rand_word(), rand_word(), rand_word(), rand_word(),
                        16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                        24'($urandom_range(0, 24'hFF_FFFF)));
            run_phase(50, 1'b0);
        end

        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
